// ===== hdl/cbc_pkg.sv =====
// Shared types, constants and helpers of the cartridge bank controller.
package cbc_pkg;

  localparam int unsigned RamDepthDef = 32768;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned RomAw       = 21;
  localparam int unsigned RamIw       = 15;

  localparam logic [7:0] OpenBus      = 8'hFF;
  localparam logic [3:0] RamEnKey     = 4'hA;
  localparam logic [4:0] RomSizeReset = 5'd15;
  localparam logic [1:0] RamSizeReset = 2'd3;
  localparam logic [4:0] LowBankReset = 5'd1;

  // bus address bits [15:13]
  localparam logic [2:0] RgnRamEn   = 3'b000;
  localparam logic [2:0] RgnRomBank = 3'b001;
  localparam logic [2:0] RgnUpper   = 3'b010;
  localparam logic [2:0] RgnMode    = 3'b011;
  localparam logic [2:0] RgnExtRam  = 3'b101;

  // configuration register indexes
  localparam logic CfgRomSize = 1'b0;
  localparam logic CfgRamSize = 1'b1;

  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } cbc_op_e;

  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_ROM,
    KIND_RAM_RD,
    KIND_RAM_WR
  } cbc_kind_e;

  typedef struct packed {
    logic [4:0] rom_size_log2;
    logic [1:0] ram_size_sel;
  } cbc_cfg_t;

  typedef struct packed {
    cbc_kind_e         kind;
    logic [RomAw-1:0]  rom_address;
    logic [RamIw-1:0]  ram_index;
    logic [7:0]        data;
  } cbc_cmd_t;

  typedef struct packed {
    logic [7:0]        read_data;
    logic              rom_fetch;
    logic [RomAw-1:0]  rom_address;
  } cbc_rsp_t;

  function automatic logic [15:0] ram_size_bytes(input logic [1:0] code);
    logic [15:0] s;
    case (code)
      2'd0:    s = 16'd0;
      2'd1:    s = 16'd2048;
      2'd2:    s = 16'd8192;
      default: s = 16'd32768;
    endcase
    return s;
  endfunction

endpackage

// ===== hdl/cartridge_bank_controller_unit.sv =====
// Top level of the cartridge bank controller: config port, queues, front and back.
// Items pass the front-to-back queue, the back-end result stage and the output queue.
// Throughput: one item per cycle while the output queue has room and no clear runs.
// The front-to-back queue and the output queue each hold QUEUE_DEPTH items.
// Reset: bank registers and config take their defaults; the RAM is then cleared
// one byte a cycle over all RAM_DEPTH addresses, during which full stays high.
module cartridge_bank_controller_unit #(
  parameter int unsigned RAM_DEPTH   = cbc_pkg::RamDepthDef,
  parameter int unsigned QUEUE_DEPTH = cbc_pkg::QueueDepth
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [2:0]                paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  input  logic                      push,
  output logic                      full,
  input  logic                      opcode_i,
  input  logic [15:0]               address_i,
  input  logic [7:0]                write_data_i,
  output logic                      empty,
  input  logic                      pop,
  output logic [7:0]                read_data_o,
  output logic                      rom_fetch_o,
  output logic [cbc_pkg::RomAw-1:0] rom_address_o
);
  import cbc_pkg::*;

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  cbc_cfg_t           cfg_q, cfg_d;
  logic               cfg_wr, accept;
  cbc_cmd_t           front_cmd, back_cmd;
  logic [$bits(cbc_cmd_t)-1:0] mid_rdata;
  logic [$bits(cbc_rsp_t)-1:0] out_rdata;
  logic               mid_full, mid_empty, mid_pop;
  logic [CW-1:0]      mid_count;
  logic               clearing;
  logic               rsp_push;
  cbc_rsp_t           rsp, out_rsp;
  logic [CW-1:0]      out_count;
  logic               out_full;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      case (paddr[2])
        CfgRomSize: cfg_d.rom_size_log2 = pwdata[4:0];
        CfgRamSize: cfg_d.ram_size_sel  = pwdata[1:0];
        default:    ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      CfgRomSize: prdata = {27'b0, cfg_q.rom_size_log2};
      CfgRamSize: prdata = {30'b0, cfg_q.ram_size_sel};
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rom_size_log2 <= RomSizeReset;
      cfg_q.ram_size_sel  <= RamSizeReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign full   = mid_full || clearing;
  assign accept = push && !full;

  cbc_front #(
    .RAM_DEPTH(RAM_DEPTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .opcode_i     (opcode_i),
    .address_i    (address_i),
    .write_data_i (write_data_i),
    .cmd_o        (front_cmd)
  );

  cbc_fifo #(
    .WIDTH($bits(cbc_cmd_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .wdata_i (front_cmd),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .full_o  (mid_full),
    .empty_o (mid_empty),
    .count_o (mid_count)
  );

  assign back_cmd = cbc_cmd_t'(mid_rdata);

  cbc_back #(
    .RAM_DEPTH   (RAM_DEPTH),
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (back_cmd),
    .cmd_empty_i (mid_empty),
    .cmd_pop_o   (mid_pop),
    .out_count_i (out_count),
    .rsp_push_o  (rsp_push),
    .rsp_o       (rsp),
    .clearing_o  (clearing)
  );

  cbc_fifo #(
    .WIDTH($bits(cbc_rsp_t)),
    .DEPTH(QUEUE_DEPTH)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (rsp_push),
    .wdata_i (rsp),
    .pop_i   (pop),
    .rdata_o (out_rdata),
    .full_o  (out_full),
    .empty_o (empty),
    .count_o (out_count)
  );

  assign out_rsp       = cbc_rsp_t'(out_rdata);
  assign read_data_o   = out_rsp.read_data;
  assign rom_fetch_o   = out_rsp.rom_fetch;
  assign rom_address_o = out_rsp.rom_address;

  a_full_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> full)
    else $error("input open during RAM clearing");

  a_mid_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_count <= CW'(QUEUE_DEPTH))
    else $error("front-to-back queue count out of range");

  a_out_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_full |-> (out_count == CW'(QUEUE_DEPTH)))
    else $error("output queue full flag inconsistent");

endmodule

// ===== hdl/cbc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/cbc_fifo.sv =====
// Small first-in first-out item queue with fill count.
module cbc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       full_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);

  localparam int unsigned PW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign rdata_o = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== hdl/cbc_front.sv =====
// Front end: bank registers, address decode and item classification.
module cbc_front #(
  parameter int unsigned RAM_DEPTH = cbc_pkg::RamDepthDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cbc_pkg::cbc_cfg_t cfg_i,
  input  logic              accept_i,
  input  logic              opcode_i,
  input  logic [15:0]       address_i,
  input  logic [7:0]        write_data_i,
  output cbc_pkg::cbc_cmd_t cmd_o
);
  import cbc_pkg::*;

  localparam logic [15:0] RamLimit = 16'(RAM_DEPTH);

  logic             ram_en_q, ram_en_d;
  logic [4:0]       low_q, low_d;
  logic [1:0]       upper_q, upper_d;
  logic             mode_q, mode_d;
  logic [2:0]       region;
  logic [RamIw-1:0] ram_idx;
  logic [15:0]      size_sel, usable;
  logic             ram_ok, rom_ok;
  logic [RomAw-1:0] phys;

  assign region = address_i[15:13];

  always_comb begin
    ram_idx  = mode_q ? {upper_q, address_i[12:0]} : {2'b00, address_i[12:0]};
    size_sel = ram_size_bytes(cfg_i.ram_size_sel);
    usable   = (size_sel < RamLimit) ? size_sel : RamLimit;
    ram_ok   = ram_en_q && ({1'b0, ram_idx} < usable);

    if (!address_i[14]) begin
      phys = mode_q ? {upper_q, 5'b00000, address_i[13:0]} : {7'b0, address_i[13:0]};
    end else begin
      phys = {upper_q, low_q, address_i[13:0]};
    end
    rom_ok = (cfg_i.rom_size_log2 >= 5'(RomAw)) || ((phys >> cfg_i.rom_size_log2) == '0);

    cmd_o.kind        = KIND_NONE;
    cmd_o.rom_address = '0;
    cmd_o.ram_index   = ram_idx;
    cmd_o.data        = write_data_i;
    if (opcode_i == OP_WRITE) begin
      if (region == RgnExtRam && ram_ok) begin
        cmd_o.kind = KIND_RAM_WR;
      end
    end else if (!address_i[15]) begin
      if (rom_ok) begin
        cmd_o.kind        = KIND_ROM;
        cmd_o.rom_address = phys;
      end
    end else if (region == RgnExtRam && ram_ok) begin
      cmd_o.kind = KIND_RAM_RD;
    end
  end

  always_comb begin
    ram_en_d = ram_en_q;
    low_d    = low_q;
    upper_d  = upper_q;
    mode_d   = mode_q;
    if (accept_i && opcode_i == OP_WRITE) begin
      case (region)
        RgnRamEn:   ram_en_d = (write_data_i[3:0] == RamEnKey);
        RgnRomBank: low_d    = (write_data_i[4:0] == '0) ? LowBankReset : write_data_i[4:0];
        RgnUpper:   upper_d  = write_data_i[1:0];
        RgnMode:    mode_d   = write_data_i[0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ram_en_q <= 1'b0;
      low_q    <= LowBankReset;
      upper_q  <= '0;
      mode_q   <= 1'b0;
    end else begin
      ram_en_q <= ram_en_d;
      low_q    <= low_d;
      upper_q  <= upper_d;
      mode_q   <= mode_d;
    end
  end

  a_low_bank_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    low_q != '0)
    else $error("low bank select reached zero");

endmodule

// ===== hdl/cbc_back.sv =====
// Back end: banked RAM, clearing pass and result staging.
module cbc_back #(
  parameter int unsigned RAM_DEPTH   = cbc_pkg::RamDepthDef,
  parameter int unsigned QUEUE_DEPTH = cbc_pkg::QueueDepth
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  cbc_pkg::cbc_cmd_t                cmd_i,
  input  logic                             cmd_empty_i,
  output logic                             cmd_pop_o,
  input  logic [$clog2(QUEUE_DEPTH+1)-1:0] out_count_i,
  output logic                             rsp_push_o,
  output cbc_pkg::cbc_rsp_t                rsp_o,
  output logic                             clearing_o
);
  import cbc_pkg::*;

  localparam int unsigned AW = $clog2(RAM_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

  logic             clr_q, clr_d;
  logic [AW-1:0]    clr_addr_q, clr_addr_d;
  logic             issue;
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata, ram_rdata;
  logic             v_q, rd_q;
  logic             fetch_q;
  logic [RomAw-1:0] rom_addr_q;

  // results in flight must always find room in the output queue
  assign issue = !clr_q && !cmd_empty_i &&
                 (({1'b0, out_count_i} + (CW + 1)'(v_q)) < (CW + 1)'(QUEUE_DEPTH));
  assign cmd_pop_o  = issue;
  assign clearing_o = clr_q;

  always_comb begin
    clr_d      = clr_q;
    clr_addr_d = clr_addr_q;
    if (clr_q) begin
      if (clr_addr_q == AW'(RAM_DEPTH - 1)) begin
        clr_d = 1'b0;
      end else begin
        clr_addr_d = clr_addr_q + AW'(1);
      end
    end
  end

  assign ram_we    = clr_q || (issue && cmd_i.kind == KIND_RAM_WR);
  assign ram_waddr = clr_q ? clr_addr_q : cmd_i.ram_index[AW-1:0];
  assign ram_wdata = clr_q ? '0 : cmd_i.data;
  assign ram_re    = issue && cmd_i.kind == KIND_RAM_RD;

  cbc_ram #(
    .WIDTH(8),
    .DEPTH(RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (cmd_i.ram_index[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
      v_q        <= 1'b0;
    end else begin
      clr_q      <= clr_d;
      clr_addr_q <= clr_addr_d;
      v_q        <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      rd_q       <= (cmd_i.kind == KIND_RAM_RD);
      fetch_q    <= (cmd_i.kind == KIND_ROM);
      rom_addr_q <= cmd_i.rom_address;
    end
  end

  assign rsp_push_o        = v_q;
  assign rsp_o.read_data   = rd_q ? ram_rdata : OpenBus;
  assign rsp_o.rom_fetch   = fetch_q;
  assign rsp_o.rom_address = rom_addr_q;

  a_out_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> (out_count_i < CW'(QUEUE_DEPTH)))
    else $error("result pushed into a full output queue");

  a_no_issue_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_q |-> !cmd_pop_o)
    else $error("item issued during RAM clearing");

  a_clear_complete: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_q) |-> ($past(clr_addr_q) == AW'(RAM_DEPTH - 1)))
    else $error("RAM clearing ended early");

endmodule

// ===== sim/cartridge_bank_controller_unit_test.sv =====
// Self-checking testbench for the cartridge bank controller: directed and random bus accesses.
`timescale 1ns / 100ps

module cartridge_bank_controller_unit_test;
  import cbc_pkg::*;

  localparam int unsigned StallLimit = 100000;
  localparam int unsigned RecentMax  = 16;

  typedef struct packed {
    logic [7:0]       read_data;
    logic             rom_fetch;
    logic [RomAw-1:0] rom_address;
  } bus_reply_t;

  logic              clk_i        = 1'b0;
  logic              rst_ni       = 1'b0;
  logic              psel         = 1'b0;
  logic              penable      = 1'b0;
  logic              pwrite       = 1'b0;
  logic [2:0]        paddr        = '0;
  logic [31:0]       pwdata       = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              push         = 1'b0;
  logic              full;
  logic              opcode_i     = 1'b0;
  logic [15:0]       address_i    = '0;
  logic [7:0]        write_data_i = '0;
  logic              empty;
  logic              pop          = 1'b0;
  logic [7:0]        read_data_o;
  logic              rom_fetch_o;
  logic [RomAw-1:0]  rom_address_o;

  // shadow of the controller state
  logic       ram_on;
  logic [4:0] low_bank;
  logic [1:0] upper_sel;
  logic       mode_sel;
  logic [4:0] rom_log2;
  logic [1:0] ram_code;
  logic [7:0] cart_ram [RamDepthDef];

  bus_reply_t  bus_replies [$];
  bus_reply_t  want;
  logic [15:0] recent_ram_addrs [$];
  int unsigned error_count  = 0;
  int unsigned stall_cycles = 0;
  int unsigned sender_idle_pct   = 0;
  int unsigned receiver_idle_pct = 0;

  cartridge_bank_controller_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .push          (push),
    .full          (full),
    .opcode_i      (opcode_i),
    .address_i     (address_i),
    .write_data_i  (write_data_i),
    .empty         (empty),
    .pop           (pop),
    .read_data_o   (read_data_o),
    .rom_fetch_o   (rom_fetch_o),
    .rom_address_o (rom_address_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic bus_reply_t apply_bus_access(cbc_op_e op, logic [15:0] addr,
                                                  logic [7:0] data);
    bus_reply_t  r;
    int unsigned ram_idx;
    int unsigned ram_limit;
    logic [63:0] phys;
    logic        ram_hit;
    r.read_data   = OpenBus;
    r.rom_fetch   = 1'b0;
    r.rom_address = '0;
    ram_idx = int'(addr[12:0]);
    if (mode_sel) ram_idx = ram_idx + int'(upper_sel) * 32'h2000;
    case (ram_code)
      2'd0:    ram_limit = 0;
      2'd1:    ram_limit = 2048;
      2'd2:    ram_limit = 8192;
      default: ram_limit = 32768;
    endcase
    ram_hit = (addr[15:13] == RgnExtRam) && ram_on && (ram_idx < ram_limit);
    if (op == OP_WRITE) begin
      case (addr[15:13])
        RgnRamEn:   ram_on = (data[3:0] == RamEnKey);
        RgnRomBank: low_bank = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
        RgnUpper:   upper_sel = data[1:0];
        RgnMode:    mode_sel = data[0];
        RgnExtRam:  if (ram_hit) cart_ram[ram_idx] = data;
        default: ;
      endcase
    end else if (!addr[15]) begin
      if (!addr[14]) begin
        phys = 64'(addr);
        if (mode_sel) phys = phys + (64'(upper_sel) << 19);
      end else begin
        phys = (64'({upper_sel, low_bank}) << 14) + 64'(addr[13:0]);
      end
      if (phys < (64'd1 << rom_log2)) begin
        r.rom_fetch   = 1'b1;
        r.rom_address = phys[RomAw-1:0];
      end
    end else if (ram_hit) begin
      r.read_data = cart_ram[ram_idx];
    end
    return r;
  endfunction

  task automatic send_access(cbc_op_e op, logic [15:0] addr, logic [7:0] data);
    while ($urandom_range(99) < sender_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    opcode_i     <= op;
    address_i    <= addr;
    write_data_i <= data;
    do @(posedge clk_i); while (full);
    bus_replies.push_back(apply_bus_access(op, addr, data));
  endtask

  task automatic write_cfg_reg(logic idx, logic [31:0] value);
    logic [31:0] stored;
    stored = (idx == CfgRomSize) ? {27'd0, value[4:0]} : {30'd0, value[1:0]};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == CfgRomSize) rom_log2 = value[4:0];
    else ram_code = value[1:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== stored) begin
      $error("prdata: expected %08h, got %08h", stored, prdata);
      error_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // drain every outstanding item before touching the registers
  task automatic reconfigure(logic [4:0] rom_sz, logic [1:0] ram_sz);
    push <= 1'b0;
    while (bus_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    write_cfg_reg(CfgRomSize, ($urandom() & ~32'h1F) | 32'(rom_sz));
    write_cfg_reg(CfgRamSize, ($urandom() & ~32'h3) | 32'(ram_sz));
  endtask

  task automatic send_random_access();
    int unsigned pick;
    int unsigned region;
    logic [12:0] offset;
    logic [15:0] addr;
    logic [7:0]  data;
    pick   = $urandom_range(99);
    data   = 8'($urandom());
    offset = ($urandom_range(1) != 0) ? 13'($urandom_range(13'h7FF)) : 13'($urandom());
    if (pick < 12) begin
      region = $urandom_range(3);
      addr   = {3'(region), 13'($urandom())};
      if (region == 0 && $urandom_range(3) != 0) data[3:0] = RamEnKey;
      send_access(OP_WRITE, addr, data);
    end else if (pick < 37) begin
      addr = {RgnExtRam, offset};
      recent_ram_addrs.push_back(addr);
      if (recent_ram_addrs.size() > RecentMax) void'(recent_ram_addrs.pop_front());
      send_access(OP_WRITE, addr, data);
    end else if (pick < 62) begin
      if (recent_ram_addrs.size() != 0 && $urandom_range(9) < 6)
        addr = recent_ram_addrs[$urandom_range(recent_ram_addrs.size() - 1)];
      else
        addr = {RgnExtRam, offset};
      send_access(OP_READ, addr, data);
    end else if (pick < 87) begin
      send_access(OP_READ, {1'b0, 15'($urandom())}, data);
    end else begin
      send_access(cbc_op_e'($urandom_range(1)), 16'($urandom()), data);
    end
  endtask

  task automatic test_reset_state();
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'h7FFF, 8'hFF);
    send_access(OP_WRITE, 16'hA000, 8'h55);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_READ,  16'h8000, 8'h00);
    send_access(OP_READ,  16'h9FFF, 8'h00);
    send_access(OP_READ,  16'hC000, 8'h00);
    send_access(OP_READ,  16'hFFFF, 8'h00);
  endtask

  task automatic test_bank_registers();
    send_access(OP_WRITE, 16'h2000, 8'h00);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h3FFF, 8'hFF);
    send_access(OP_READ,  16'h4000, 8'h00);
    send_access(OP_WRITE, 16'h4000, 8'hFF);
    send_access(OP_WRITE, 16'h7FFF, 8'h01);
    send_access(OP_READ,  16'h3FFF, 8'h00);
  endtask

  task automatic test_rom_banking();
    reconfigure(5'd21, 2'd3);
    send_access(OP_READ,  16'h0000, 8'h00);
    send_access(OP_READ,  16'h7FFF, 8'h00);
    send_access(OP_WRITE, 16'h6000, 8'hFE);
    send_access(OP_READ,  16'h3FFF, 8'h00);
  endtask

  task automatic test_ram_access();
    send_access(OP_WRITE, 16'h1FFF, 8'hFA);
    send_access(OP_WRITE, 16'hBFFF, 8'hFF);
    send_access(OP_READ,  16'hBFFF, 8'h00);
    send_access(OP_WRITE, 16'h6000, 8'h01);
    send_access(OP_WRITE, 16'hA000, 8'hA5);
    send_access(OP_READ,  16'hA000, 8'h00);
    send_access(OP_WRITE, 16'h0000, 8'h0B);
    send_access(OP_READ,  16'hA000, 8'h00);
  endtask

  task automatic test_random_traffic(logic [4:0] rom_sz, logic [1:0] ram_sz, int unsigned n);
    reconfigure(rom_sz, ram_sz);
    repeat (n) send_random_access();
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (bus_replies.size() == 0) begin
          $error("unexpected item: read_data %02h rom_fetch %0b rom_address %06h",
                 read_data_o, rom_fetch_o, rom_address_o);
          error_count++;
        end else begin
          want = bus_replies.pop_front();
          if (read_data_o !== want.read_data) begin
            $error("read_data: expected %02h, got %02h", want.read_data, read_data_o);
            error_count++;
          end
          if (rom_fetch_o !== want.rom_fetch) begin
            $error("rom_fetch: expected %0b, got %0b", want.rom_fetch, rom_fetch_o);
            error_count++;
          end
          if (rom_address_o !== want.rom_address) begin
            $error("rom_address: expected %06h, got %06h", want.rom_address, rom_address_o);
            error_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    ram_on       = 1'b0;
    low_bank     = LowBankReset;
    upper_sel    = 2'd0;
    mode_sel     = 1'b0;
    rom_log2     = RomSizeReset;
    ram_code     = RamSizeReset;
    foreach (cart_ram[i]) cart_ram[i] = 8'h00;
    sender_idle_pct   = 35;
    receiver_idle_pct = 48;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_bank_registers();
    test_rom_banking();
    test_ram_access();
    test_random_traffic(5'd21, 2'd0, 85);
    test_random_traffic(5'd31, 2'd2, 85);
    sender_idle_pct   = 48;
    receiver_idle_pct = 35;
    test_random_traffic(5'd16, 2'd1, 85);
    test_random_traffic(5'd0,  2'd3, 85);
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    test_random_traffic(5'd19, 2'd2, 85);
    test_random_traffic(5'd15, 2'd3, 85);
    push <= 1'b0;
    while (bus_replies.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cbc_pkg.sv
hdl/cbc_ram.sv
hdl/cbc_fifo.sv
hdl/cbc_front.sv
hdl/cbc_back.sv
hdl/cartridge_bank_controller_unit.sv
sim/cartridge_bank_controller_unit_test.sv
